FILE: rtl/core/hbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the Huffman bit packer: word formats on the
// item and result channels, operation codes and the burst hand-off format.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SYMBOL_COUNT_DEF    = 256;
  localparam int MAX_CODE_LENGTH_DEF = 32;

  localparam int OP_W        = 2;
  localparam int SYMBOL_W    = 8;
  localparam int CODE_WORD_W = 32;
  localparam int CODE_LEN_W  = 6;
  localparam int BYTE_W      = 8;

  // An encode can release at most four bytes: seven pending bits plus a
  // 32-bit code make at most 39 bits.
  localparam int MAX_BURST   = 4;
  localparam int BURST_CNT_W = 3;
  localparam int PEND_CNT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_WORD_W-1:0] code_word;
    logic [CODE_LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } result_t;

  // Bytes released by one item, handed from the packer to the emitter.
  typedef struct packed {
    logic                        valid;
    logic [MAX_BURST*BYTE_W-1:0] data;
    logic [BURST_CNT_W-1:0]      count;
  } burst_t;

endpackage

FILE: rtl/core/hbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single-write, single-read synchronous RAM. Read data is registered
// and holds its value on cycles without a read.
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/hbp_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_packer
// Table-read stage and bit accumulator. Merge the looked-up code into the
// pending bits and release every full byte as one burst; flush a partial one.
// ----------------------------------------------------------------------------
module hbp_packer
  import hbp_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [OP_W-1:0] op,
  input  logic            sym_ok,
  input  logic            hit,
  input  logic [CODE_WORD_W+$clog2(((MAX_CODE_LENGTH < CODE_WORD_W) ?
                                     MAX_CODE_LENGTH : CODE_WORD_W) + 1)-1:0] rd_data,
  input  logic            burst_free,
  output logic            ready,
  output burst_t          brq
);

  localparam int LEN_CAP = (MAX_CODE_LENGTH < CODE_WORD_W) ? MAX_CODE_LENGTH : CODE_WORD_W;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int MERGE_W = CODE_WORD_W + BYTE_W;

  logic                   s1_valid;
  logic [OP_W-1:0]        s1_op;
  logic                   s1_ok;
  logic                   s1_hit;
  logic [BYTE_W-1:0]      acc;
  logic [PEND_CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0]      acc_next;
  logic [PEND_CNT_W-1:0]  cnt_next;

  logic [CODE_LEN_W-1:0]  clen;
  logic [CODE_WORD_W-1:0] mask;
  logic [CODE_WORD_W-1:0] bits;
  logic [MERGE_W-1:0]     merged;
  logic [CODE_LEN_W-1:0]  total;
  logic [BURST_CNT_W-1:0] nbytes;
  logic [MAX_BURST*BYTE_W-1:0] bytes;
  logic                   adv;

  always_comb begin
    clen = '0;
    if (s1_op == OP_ENCODE && s1_ok && s1_hit) begin
      clen = CODE_LEN_W'(rd_data[CODE_WORD_W +: LEN_W]);
    end
    for (int i = 0; i < CODE_WORD_W; i++) begin
      mask[i] = (CODE_LEN_W'(i) < clen);
    end
    bits   = rd_data[CODE_WORD_W-1:0] & mask;
    merged = ({{BYTE_W{1'b0}}, bits} << cnt) | {{CODE_WORD_W{1'b0}}, acc};
    total  = {{(CODE_LEN_W-PEND_CNT_W){1'b0}}, cnt} + clen;

    nbytes   = '0;
    bytes    = '0;
    acc_next = acc;
    cnt_next = cnt;
    case (s1_op)
      OP_ENCODE: begin
        nbytes   = total[CODE_LEN_W-1:PEND_CNT_W];
        bytes    = merged[MAX_BURST*BYTE_W-1:0];
        acc_next = BYTE_W'(merged >> {nbytes, 3'b000});
        cnt_next = total[PEND_CNT_W-1:0];
      end
      OP_FLUSH: begin
        nbytes   = (cnt != '0) ? BURST_CNT_W'(1) : '0;
        bytes    = {{((MAX_BURST-1)*BYTE_W){1'b0}}, acc};
        acc_next = '0;
        cnt_next = '0;
      end
      default: begin
        nbytes = '0;
      end
    endcase

    adv       = s1_valid && (nbytes == '0 || burst_free);
    ready     = !s1_valid || adv;
    brq.valid = adv && (nbytes != '0);
    brq.data  = bytes;
    brq.count = nbytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
      cnt      <= '0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        acc <= acc_next;
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_op  <= op;
      s1_ok  <= sym_ok;
      s1_hit <= hit;
    end
  end

endmodule

FILE: rtl/core/hbp_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_emitter
// Result register. Hold one burst and hand it out a byte per word, marking
// the final byte of the burst.
// ----------------------------------------------------------------------------
module hbp_emitter
  import hbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  burst_t  brq,
  input  logic    res_stall,
  output logic    free,
  output logic    res_valid,
  output result_t res
);

  logic [MAX_BURST*BYTE_W-1:0] data;
  logic [BURST_CNT_W-1:0]      rem;
  logic                        take;

  assign take         = res_valid && !res_stall;
  assign free         = !res_valid || (take && rem == BURST_CNT_W'(1));
  assign res.out_byte = data[BYTE_W-1:0];
  assign res.last     = (rem == BURST_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      rem       <= '0;
    end else if (brq.valid) begin
      res_valid <= 1'b1;
      rem       <= brq.count;
    end else if (take) begin
      res_valid <= (rem != BURST_CNT_W'(1));
      rem       <= rem - BURST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (brq.valid) begin
      data <= brq.data;
    end else if (take) begin
      data <= data >> BYTE_W;
    end
  end

endmodule

FILE: rtl/core/huffman_bit_packer.sv
`timescale 1ns / 1ps
// Path: an item's first byte reaches res through the registered table read
//   and then the result register, which the merge loads.
// Throughput: one item per cycle while res is not stalled and each item
//   releases at most one byte, as the n bytes of an item share one result port.
// Reset: synchronous; clears the pending bits and the per-entry valid bits of
//   the code table at once, so the table reads as empty with no sweep.
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Huffman encoder back end: code table in a synchronous RAM plus an LSB-first
// bit accumulator that packs code bits into bytes.
// ----------------------------------------------------------------------------
module huffman_bit_packer
  import hbp_pkg::*;
#(
  parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  localparam int LEN_CAP = (MAX_CODE_LENGTH < CODE_WORD_W) ? MAX_CODE_LENGTH : CODE_WORD_W;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = CODE_WORD_W + LEN_W;

  logic                    item_fire;
  logic                    ready;
  logic                    sym_ok;
  logic [SYM_W-1:0]        addr;
  logic [LEN_W-1:0]        len_sat;
  logic                    load_en;
  logic                    read_en;
  logic [ENTRY_W-1:0]      rd_data;
  logic [SYMBOL_COUNT-1:0] code_valid;
  logic                    burst_free;
  burst_t                  brq;

  // Accept whenever the merge stage is empty or moving on this cycle.
  assign item_stall = !ready;
  assign item_fire  = item_valid && ready;

  // Symbols past the table are dropped on load and encode as empty codes.
  assign sym_ok  = ({1'b0, item.symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT));
  assign addr    = item.symbol[SYM_W-1:0];
  // Saturate the loaded length to what the code word can hold.
  assign len_sat = (item.code_length > CODE_LEN_W'(LEN_CAP)) ?
                   LEN_W'(LEN_CAP) : item.code_length[LEN_W-1:0];

  // Loads write at their accept edge; an encode reads at its own accept edge,
  // which comes after the load's, so it always sees the newest entry. The read
  // data register holds while the merge stage is stalled.
  assign load_en = item_fire && (item.op == OP_LOAD) && sym_ok;
  assign read_en = item_fire && (item.op == OP_ENCODE);

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (addr),
    .wr_data ({len_sat, item.code_word}),
    .rd_en   (read_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Per-entry valid bits: an entry never loaded since reset reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= '0;
    end else if (load_en) begin
      code_valid[addr] <= 1'b1;
    end
  end

  hbp_packer #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_packer (
    .clk        (clk),
    .rst        (rst),
    .fire       (item_fire),
    .op         (item.op),
    .sym_ok     (sym_ok),
    .hit        (code_valid[addr]),
    .rd_data    (rd_data),
    .burst_free (burst_free),
    .ready      (ready),
    .brq        (brq)
  );

  hbp_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .brq       (brq),
    .res_stall (res_stall),
    .free      (burst_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // A burst is never handed over while the result register still holds bytes.
  a_burst_into_free: assert property (@(posedge clk) disable iff (rst)
    brq.valid |-> burst_free)
    else $error("burst loaded over undelivered bytes");

  // A byte taken that is not the last of its burst is followed by another.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res.last) |=> res_valid)
    else $error("burst ended before its last byte");

  // An in-range load marks its table entry as written.
  a_load_marks_entry: assert property (@(posedge clk) disable iff (rst)
    load_en |=> code_valid[$past(addr)])
    else $error("loaded entry not marked valid");

  // Nothing is presented right after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !res_valid)
    else $error("result presented right after reset");

endmodule
